/* sv/qpht_pkg.sv */
`timescale 1ns / 1ps

package qpht_pkg;

   localparam int KIND_WIDTH    = 2;
   localparam int KEY_WIDTH     = 40;
   localparam int PAYLOAD_WIDTH = 64;
   localparam int STATUS_WIDTH  = 2;
   localparam int SLOT_WIDTH    = 4;

   localparam int TABLE_SIZE_DEFAULT = 16;

   // The home-slot residue consumes this many key bits per cycle.
   localparam int MOD_STEP   = 4;
   localparam int MOD_CYCLES = KEY_WIDTH / MOD_STEP;
   localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_INSERT = 2'd0,
      KIND_SEARCH = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_ZERO = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_HOME,
      ST_READ,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mod_step;
      logic       probe_init;
      logic       advance;
      logic       wr_ins;
      logic       wr_clr;
      logic       clr_adv;
      logic       rsp_valid;
      status_type rsp_status;
      logic       rsp_slot;
      logic       rsp_payload;
   } cmd_type;

   typedef struct packed {
      logic     req_key_zero;
      logic     mod_last;
      logic     first_probe;
      logic     last_probe;
      logic     data_empty;
      logic     data_match;
      logic     clr_last;
      kind_type kind;
   } stat_type;

endpackage

/* sv/quadratic_probe_hash_table.sv */
`timescale 1ns / 1ps

// Open-addressing hash table with quadratic probing: TABLE_SIZE slots of a
// 40-bit key and a 64-bit payload, key 0 meaning empty. A request is taken
// when start is high and busy is low; exactly one result follows, shown for
// one cycle with rsp_valid high, and the receiver cannot stall it, so it must
// take every result in that cycle. A request with kind 3 or a zero key is
// answered in the cycle after it is taken. Any other request first forms the
// home slot (key mod TABLE_SIZE, four key bits a cycle), then sets up the
// probe, then makes up to TABLE_SIZE probes, each a table read and then a
// compare and write; the result is registered from the check of the last
// probe. The table read is registered, so each probe has its own read state.
// After reset busy stays high while the table is cleared.

module quadratic_probe_hash_table #(
   parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [qpht_pkg::KIND_WIDTH-1:0]    req_kind,
   input  logic [qpht_pkg::KEY_WIDTH-1:0]     req_key,
   input  logic [qpht_pkg::PAYLOAD_WIDTH-1:0] req_payload,
   output logic                               rsp_valid,
   output logic [qpht_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic [qpht_pkg::SLOT_WIDTH-1:0]    rsp_slot,
   output logic [qpht_pkg::PAYLOAD_WIDTH-1:0] rsp_found_payload
);

   qpht_pkg::cmd_type  cmd;
   qpht_pkg::stat_type stat;

   qpht_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   qpht_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_found_payload (rsp_found_payload)
   );

endmodule

/* sv/qpht_ram.sv */
`timescale 1ns / 1ps

module qpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/qpht_datapath.sv */
`timescale 1ns / 1ps

module qpht_datapath #(
   parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  qpht_pkg::cmd_type                   cmd,
   output qpht_pkg::stat_type                  stat,
   input  logic [qpht_pkg::KIND_WIDTH-1:0]     req_kind,
   input  logic [qpht_pkg::KEY_WIDTH-1:0]      req_key,
   input  logic [qpht_pkg::PAYLOAD_WIDTH-1:0]  req_payload,
   output logic                                rsp_valid,
   output logic [qpht_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic [qpht_pkg::SLOT_WIDTH-1:0]     rsp_slot,
   output logic [qpht_pkg::PAYLOAD_WIDTH-1:0]  rsp_found_payload
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int KW = qpht_pkg::KEY_WIDTH;
   localparam int PW = qpht_pkg::PAYLOAD_WIDTH;
   localparam int SW = qpht_pkg::SLOT_WIDTH;
   localparam logic [AW:0]   N_W  = (AW+1)'(TABLE_SIZE);
   localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

   qpht_pkg::kind_type   kind_ff;
   logic [KW-1:0]        key_ff;
   logic [PW-1:0]        payload_ff;
   logic [KW-1:0]        key_sh_ff;
   logic [KW-1:0]        key_sh_in;
   logic [AW-1:0]        res_ff;
   logic [AW-1:0]        res_in;
   logic [qpht_pkg::MOD_CNT_W-1:0] mod_cnt_ff;
   logic [AW-1:0]        addr_ff;
   logic [AW-1:0]        addr_in;
   logic [AW-1:0]        step_ff;
   logic [AW-1:0]        step_in;
   logic [AW-1:0]        idx_ff;
   logic [AW:0]          acc;
   logic [AW:0]          addr_sum;
   logic [AW:0]          step_sum;
   logic [AW+SW-1:0]     slot_ext;

   logic                 rsp_valid_ff;
   qpht_pkg::status_type rsp_status_ff;
   logic [SW-1:0]        rsp_slot_ff;
   logic [PW-1:0]        rsp_payload_ff;

   logic                 ram_we;
   logic [KW-1:0]        key_wdata;
   logic [PW-1:0]        pay_wdata;
   logic [KW-1:0]        key_rdata;
   logic [PW-1:0]        pay_rdata;

   // Residue of the key by the table size, most significant bits first:
   // each bit doubles the residue and one compare and subtract keeps it below N.
   always_comb begin
      acc = {1'b0, res_ff};
      for (int j = 0; j < qpht_pkg::MOD_STEP; j++) begin
         acc = {acc[AW-1:0], key_sh_ff[KW-1-j]};
         if (acc >= N_W) begin
            acc = acc - N_W;
         end
      end
      res_in    = acc[AW-1:0];
      key_sh_in = key_sh_ff << qpht_pkg::MOD_STEP;
   end

   // Next probe: the offset i*i grows by 2i+1, kept as a residue in step_ff.
   always_comb begin
      addr_sum = {1'b0, addr_ff} + {1'b0, step_ff};
      if (addr_sum >= N_W) begin
         addr_sum = addr_sum - N_W;
      end
      step_sum = {1'b0, step_ff} + (AW+1)'(2);
      if (step_sum >= N_W) begin
         step_sum = step_sum - N_W;
      end
      addr_in = addr_sum[AW-1:0];
      step_in = step_sum[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= qpht_pkg::kind_type'(req_kind);
         key_ff     <= req_key;
         payload_ff <= req_payload;
         key_sh_ff  <= req_key;
         res_ff     <= '0;
         mod_cnt_ff <= '0;
      end else if (cmd.mod_step) begin
         key_sh_ff  <= key_sh_in;
         res_ff     <= res_in;
         mod_cnt_ff <= mod_cnt_ff + qpht_pkg::MOD_CNT_W'(1);
      end
      if (cmd.probe_init) begin
         step_ff <= AW'(1);
         idx_ff  <= '0;
      end else if (cmd.advance) begin
         step_ff <= step_in;
         idx_ff  <= idx_ff + AW'(1);
      end
   end

   // The probe address doubles as the pointer of the clearing pass after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else if (cmd.probe_init) begin
         addr_ff <= res_ff;
      end else if (cmd.advance) begin
         addr_ff <= addr_in;
      end else if (cmd.clr_adv) begin
         addr_ff <= (addr_ff == LAST) ? '0 : addr_ff + AW'(1);
      end
   end

   assign ram_we    = cmd.wr_ins | cmd.wr_clr;
   assign key_wdata = cmd.wr_ins ? key_ff : '0;
   assign pay_wdata = cmd.wr_ins ? payload_ff : '0;

   qpht_ram #(
      .WIDTH (KW),
      .DEPTH (TABLE_SIZE)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (key_wdata),
      .rd_addr (addr_ff),
      .rd_data (key_rdata)
   );

   qpht_ram #(
      .WIDTH (PW),
      .DEPTH (TABLE_SIZE)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (pay_wdata),
      .rd_addr (addr_ff),
      .rd_data (pay_rdata)
   );

   assign slot_ext = {{SW{1'b0}}, addr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_valid;
      end
      if (cmd.rsp_valid) begin
         rsp_status_ff  <= cmd.rsp_status;
         rsp_slot_ff    <= cmd.rsp_slot ? slot_ext[SW-1:0] : '0;
         rsp_payload_ff <= cmd.rsp_payload ? pay_rdata : '0;
      end
   end

   assign stat.req_key_zero = (req_key == '0);
   assign stat.mod_last     = (mod_cnt_ff == qpht_pkg::MOD_CNT_W'(qpht_pkg::MOD_CYCLES - 1));
   assign stat.first_probe  = (idx_ff == '0);
   assign stat.last_probe   = (idx_ff == LAST);
   assign stat.data_empty   = (key_rdata == '0);
   assign stat.data_match   = (key_rdata == key_ff);
   assign stat.clr_last     = (addr_ff == LAST);
   assign stat.kind         = kind_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_found_payload = rsp_payload_ff;

   a_insert_into_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_ins |-> stat.data_empty)
      else $error("insert writes over an occupied slot");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, addr_ff} < N_W)
      else $error("probe address beyond the table");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |=> {1'b0, step_ff} < N_W)
      else $error("probe step residue beyond the table size");

   a_found_payload_only_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_payload |-> cmd.rsp_valid && cmd.rsp_status == qpht_pkg::STATUS_OK)
      else $error("payload returned without a successful search");

endmodule

/* sv/qpht_ctrl.sv */
`timescale 1ns / 1ps

module qpht_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [qpht_pkg::KIND_WIDTH-1:0] req_kind,
   input  qpht_pkg::stat_type              stat,
   output qpht_pkg::cmd_type               cmd,
   output logic                            busy
);

   qpht_pkg::state_type state_ff;
   qpht_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qpht_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != qpht_pkg::ST_IDLE);
      case (state_ff)
         qpht_pkg::ST_CLEAR: begin
            cmd.wr_clr  = 1'b1;
            cmd.clr_adv = 1'b1;
            if (stat.clr_last) begin
               state_in = qpht_pkg::ST_IDLE;
            end
         end
         qpht_pkg::ST_IDLE: begin
            if (start) begin
               if (qpht_pkg::kind_type'(req_kind) == qpht_pkg::KIND_UNUSED) begin
                  cmd.rsp_valid  = 1'b1;
                  cmd.rsp_status = qpht_pkg::STATUS_MISS;
               end else if (stat.req_key_zero) begin
                  cmd.rsp_valid  = 1'b1;
                  cmd.rsp_status = qpht_pkg::STATUS_ZERO;
               end else begin
                  cmd.load = 1'b1;
                  state_in = qpht_pkg::ST_MOD;
               end
            end
         end
         qpht_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) begin
               state_in = qpht_pkg::ST_HOME;
            end
         end
         qpht_pkg::ST_HOME: begin
            cmd.probe_init = 1'b1;
            state_in       = qpht_pkg::ST_READ;
         end
         qpht_pkg::ST_READ: begin
            state_in = qpht_pkg::ST_CHECK;
         end
         qpht_pkg::ST_CHECK: begin
            if (stat.kind == qpht_pkg::KIND_INSERT) begin
               if (stat.data_empty) begin
                  cmd.wr_ins     = 1'b1;
                  cmd.rsp_valid  = 1'b1;
                  cmd.rsp_status = qpht_pkg::STATUS_OK;
                  cmd.rsp_slot   = 1'b1;
                  state_in       = qpht_pkg::ST_IDLE;
               end else if (stat.last_probe) begin
                  cmd.rsp_valid  = 1'b1;
                  cmd.rsp_status = qpht_pkg::STATUS_FULL;
                  state_in       = qpht_pkg::ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = qpht_pkg::ST_READ;
               end
            end else begin
               // An empty home slot ends a lookup at once; later empty slots
               // are passed over.
               if (stat.first_probe && stat.data_empty) begin
                  cmd.rsp_valid  = 1'b1;
                  cmd.rsp_status = qpht_pkg::STATUS_MISS;
                  state_in       = qpht_pkg::ST_IDLE;
               end else if (stat.data_match) begin
                  cmd.wr_clr      = (stat.kind == qpht_pkg::KIND_DELETE);
                  cmd.rsp_valid   = 1'b1;
                  cmd.rsp_status  = qpht_pkg::STATUS_OK;
                  cmd.rsp_slot    = 1'b1;
                  cmd.rsp_payload = (stat.kind == qpht_pkg::KIND_SEARCH);
                  state_in        = qpht_pkg::ST_IDLE;
               end else if (stat.last_probe) begin
                  cmd.rsp_valid  = 1'b1;
                  cmd.rsp_status = qpht_pkg::STATUS_MISS;
                  state_in       = qpht_pkg::ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = qpht_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = qpht_pkg::ST_IDLE;
         end
      endcase
   end

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == qpht_pkg::ST_IDLE && start)
      else $error("request loaded outside idle");

   a_write_needs_probe: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_ins |-> state_ff == qpht_pkg::ST_CHECK)
      else $error("insert write outside a probe check");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_valid && state_ff == qpht_pkg::ST_CHECK) |=>
         state_ff == qpht_pkg::ST_IDLE)
      else $error("controller did not return to idle after a result");

endmodule
